### rtl/sqmm_pkg.sv
package sqmm_pkg;

  localparam logic [3:0] MAX_SIZE    = 4'd8;
  localparam int         STORE_DEPTH = 64;
  localparam int         ADDR_W      = 6;
  localparam int         ELEM_W      = 16;
  localparam int         PROD_W      = 32;
  localparam int         SUM_W       = 36;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_element;
    logic signed [ELEM_W-1:0] b_element;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] c_element;
    logic        [2:0]       row_index;
    logic        [2:0]       column_index;
    logic                    last_of_run;
  } out_t;

  // Travels with each multiply-accumulate through the datapath
  typedef struct packed {
    logic       first;
    logic       last;
    logic [2:0] row;
    logic [2:0] col;
    logic       end_of_run;
  } tag_t;

endpackage

### rtl/sqmm_ram.sv
module sqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/sqmm_mac.sv
module sqmm_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  op_valid,
  input  sqmm_pkg::tag_t                        op_tag,
  input  logic signed [sqmm_pkg::ELEM_W-1:0]    op_a,
  input  logic signed [sqmm_pkg::ELEM_W-1:0]    op_b,
  output logic                                  prod_valid,
  output logic                                  res_strobe,
  output sqmm_pkg::out_t                        res
);

  logic signed [sqmm_pkg::PROD_W-1:0] prod;
  sqmm_pkg::tag_t                     prod_tag;
  logic signed [sqmm_pkg::SUM_W-1:0]  acc;
  logic signed [sqmm_pkg::SUM_W-1:0]  acc_next;
  logic signed [sqmm_pkg::SUM_W-1:0]  prod_ext;

  assign prod_ext = sqmm_pkg::SUM_W'(prod);
  // Restart the sum on the first term of each inner product; wrap at 36 bits
  assign acc_next = (prod_tag.first ? '0 : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      res_strobe <= 1'b0;
    end else begin
      prod_valid <= op_valid;
      res_strobe <= prod_valid && prod_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      prod     <= op_a * op_b;
      prod_tag <= op_tag;
    end
    if (prod_valid) begin
      acc <= acc_next;
      if (prod_tag.last) begin
        res.c_element    <= acc_next;
        res.row_index    <= prod_tag.row;
        res.column_index <= prod_tag.col;
        res.last_of_run  <= prod_tag.end_of_run;
      end
    end
  end

endmodule

### rtl/square_matrix_multiply_top.sv
// Loading: one transaction per cycle, busy stays low until the final element of a run.
// Final element: busy rises next cycle; n*n*n multiply-accumulates follow, one per cycle
// through a single shared multiplier; the last term of (i,j) is registered in the store
// read, product and result registers. busy stays high until the multiplier is empty.
// Results carry no backpressure: each is valid for exactly the cycle result_strobe is high.
// Reset (rst, synchronous): size 8, load count zero; element stores are not cleared.
module square_matrix_multiply_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sqmm_pkg::in_t   operand,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  output logic            result_strobe,
  output sqmm_pkg::out_t  result
);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [3:0] size_q;
  logic [6:0] load_count;
  logic [3:0] n_eff;
  logic [2:0] nm1;
  logic [6:0] total;
  logic [6:0] count_inc;
  logic       accept;

  logic [2:0] i_q, j_q, k_q;
  logic [sqmm_pkg::ADDR_W-1:0] a_addr, b_addr, row_base;
  logic [sqmm_pkg::ADDR_W-1:0] n_ext;

  logic                        issue;
  sqmm_pkg::tag_t              issue_tag;
  sqmm_pkg::tag_t              tag_q;
  logic                        tag_valid;
  logic [sqmm_pkg::ELEM_W-1:0] a_rd, b_rd;
  logic                        prod_valid;

  always_comb begin
    priority if (size_q == 4'd0) begin
      n_eff = 4'd1;
    end else if (size_q > sqmm_pkg::MAX_SIZE) begin
      n_eff = sqmm_pkg::MAX_SIZE;
    end else begin
      n_eff = size_q;
    end
  end

  assign nm1       = 3'(n_eff - 4'd1);
  assign total     = 7'(n_eff) * 7'(n_eff);
  assign count_inc = load_count + 7'd1;
  assign n_ext     = sqmm_pkg::ADDR_W'(n_eff);
  assign busy      = (state != S_LOAD);
  assign accept    = start && !busy;
  assign issue     = (state == S_RUN);

  always_comb begin
    issue_tag.first      = (k_q == 3'd0);
    issue_tag.last       = (k_q == nm1);
    issue_tag.row        = i_q;
    issue_tag.col        = j_q;
    issue_tag.end_of_run = (k_q == nm1) && (i_q == nm1) && (j_q == nm1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && !cfg_we && (count_inc >= total)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if ((k_q == nm1) && (j_q == nm1) && (i_q == nm1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Hold until the last term has left the multiplier
        if (!tag_valid && !prod_valid) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      size_q     <= sqmm_pkg::MAX_SIZE;
      load_count <= '0;
      tag_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      tag_valid <= issue;
      if (cfg_we) begin
        size_q     <= cfg_data;
        load_count <= '0;
      end else if (accept) begin
        load_count <= (count_inc >= total) ? 7'd0 : count_inc;
      end
    end
  end

  // Loop counters: k innermost, then column, then row
  always_ff @(posedge clk) begin
    if (rst) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
      row_base <= '0;
    end else if (state == S_LOAD) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
      row_base <= '0;
    end else if (issue) begin
      if (k_q != nm1) begin
        k_q    <= k_q + 3'd1;
        a_addr <= a_addr + sqmm_pkg::ADDR_W'(1);
        b_addr <= b_addr + n_ext;
      end else begin
        k_q <= '0;
        if (j_q != nm1) begin
          j_q    <= j_q + 3'd1;
          a_addr <= row_base;
          b_addr <= sqmm_pkg::ADDR_W'(j_q) + sqmm_pkg::ADDR_W'(1);
        end else begin
          j_q      <= '0;
          i_q      <= i_q + 3'd1;
          row_base <= row_base + n_ext;
          a_addr   <= row_base + n_ext;
          b_addr   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q <= issue_tag;
    end
  end

  sqmm_ram #(
    .WIDTH (sqmm_pkg::ELEM_W),
    .DEPTH (sqmm_pkg::STORE_DEPTH)
  ) u_a_store (
    .clk     (clk),
    .we      (accept),
    .wr_addr (load_count[sqmm_pkg::ADDR_W-1:0]),
    .wr_data (operand.a_element),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  sqmm_ram #(
    .WIDTH (sqmm_pkg::ELEM_W),
    .DEPTH (sqmm_pkg::STORE_DEPTH)
  ) u_b_store (
    .clk     (clk),
    .we      (accept),
    .wr_addr (load_count[sqmm_pkg::ADDR_W-1:0]),
    .wr_data (operand.b_element),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  sqmm_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (tag_valid),
    .op_tag     (tag_q),
    .op_a       ($signed(a_rd)),
    .op_b       ($signed(b_rd)),
    .prod_valid (prod_valid),
    .res_strobe (result_strobe),
    .res        (result)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (!tag_valid && !prod_valid))
    else $error("datapath active while loading");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result outside a run");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_of_run) |=> !result_strobe)
    else $error("result after end of run");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (load_count < total))
    else $error("load count past matrix size");

endmodule

### tb/sqmm_checker.sv
`timescale 1ns / 100ps

module sqmm_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  sqmm_pkg::in_t  operand,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_data,
  input  logic           result_strobe,
  input  sqmm_pkg::out_t result,
  input  logic           stim_done,
  output int             fail_count,
  output int             pending,
  output int             item_count,
  output int             result_count
);

  logic signed [sqmm_pkg::ELEM_W-1:0] a_mem [sqmm_pkg::STORE_DEPTH];
  logic signed [sqmm_pkg::ELEM_W-1:0] b_mem [sqmm_pkg::STORE_DEPTH];
  logic [6:0]     fill_count;
  logic [3:0]     size_reg;
  sqmm_pkg::out_t product_queue [$];
  sqmm_pkg::out_t want;
  int             mismatches = 0;
  int             accepted = 0;
  int             checked = 0;
  bit             leftovers_reported = 1'b0;

  function automatic int active_dim();
    if (size_reg == 4'd0) return 1;
    if (size_reg > sqmm_pkg::MAX_SIZE) return int'(sqmm_pkg::MAX_SIZE);
    return int'(size_reg);
  endfunction

  // Form every element of C from the stored A and B, in row-major order
  function automatic void queue_products();
    int             n;
    longint         acc;
    sqmm_pkg::out_t e;
    n = active_dim();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_mem[(i * n + k) % sqmm_pkg::STORE_DEPTH]) *
                 longint'(b_mem[(k * n + j) % sqmm_pkg::STORE_DEPTH]);
        end
        e.c_element    = acc[sqmm_pkg::SUM_W-1:0];
        e.row_index    = 3'(i);
        e.column_index = 3'(j);
        e.last_of_run  = (i == n - 1) && (j == n - 1);
        product_queue.push_back(e);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0d ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_count = '0;
      size_reg   = sqmm_pkg::MAX_SIZE;
    end else begin
      if (result_strobe !== 1'b0) begin
        if (product_queue.size() == 0) begin
          report_mismatch($sformatf("product element (%0d,%0d) with none expected",
                                    result.row_index, result.column_index));
        end else begin
          want = product_queue.pop_front();
          checked++;
          if (result.c_element !== want.c_element)
            report_mismatch($sformatf("c_element (%0d,%0d): got %0d, want %0d",
                                      want.row_index, want.column_index,
                                      result.c_element, want.c_element));
          if (result.row_index !== want.row_index)
            report_mismatch($sformatf("row_index: got %0d, want %0d",
                                      result.row_index, want.row_index));
          if (result.column_index !== want.column_index)
            report_mismatch($sformatf("column_index: got %0d, want %0d",
                                      result.column_index, want.column_index));
          if (result.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run at (%0d,%0d): got %b, want %b",
                                      want.row_index, want.column_index,
                                      result.last_of_run, want.last_of_run));
        end
      end

      // Any size write abandons a partly loaded matrix pair
      if (cfg_we) begin
        size_reg   = cfg_data;
        fill_count = '0;
      end

      if (start && !busy) begin
        a_mem[fill_count % sqmm_pkg::STORE_DEPTH] = operand.a_element;
        b_mem[fill_count % sqmm_pkg::STORE_DEPTH] = operand.b_element;
        fill_count = fill_count + 7'd1;
        accepted++;
        if (int'(fill_count) >= active_dim() * active_dim()) begin
          fill_count = '0;
          queue_products();
        end
      end

      if (stim_done && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        foreach (product_queue[q])
          report_mismatch($sformatf("product element (%0d,%0d) never arrived",
                                    product_queue[q].row_index,
                                    product_queue[q].column_index));
      end
    end

    // Publish after the edge so readers always see the settled values
    fail_count   <= mismatches;
    pending      <= product_queue.size();
    item_count   <= accepted;
    result_count <= checked;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  sqmm_pkg::in_t  operand = '0;
  logic           cfg_we = 1'b0;
  logic [3:0]     cfg_data = 4'd0;
  logic           result_strobe;
  sqmm_pkg::out_t result;
  logic           stim_done = 1'b0;

  int fail_count;
  int pending;
  int item_count;
  int result_count;

  int          burst_left = 0;
  int          random_items = 0;
  logic [15:0] codes_written = '0;

  square_matrix_multiply_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand      (operand),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .result       (result)
  );

  sqmm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand      (operand),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .result       (result),
    .stim_done    (stim_done),
    .fail_count   (fail_count),
    .pending      (pending),
    .item_count   (item_count),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int dim_of(input logic [3:0] code);
    if (code == 4'd0) return 1;
    if (code > sqmm_pkg::MAX_SIZE) return int'(sqmm_pkg::MAX_SIZE);
    return int'(code);
  endfunction

  function automatic logic signed [sqmm_pkg::ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom());
    endcase
  endfunction

  // Hold start high until the transaction is taken
  task automatic send_item(input logic signed [sqmm_pkg::ELEM_W-1:0] a,
                           input logic signed [sqmm_pkg::ELEM_W-1:0] b);
    start   <= 1'b1;
    operand <= '{a_element: a, b_element: b};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start   <= 1'b0;
      operand <= sqmm_pkg::in_t'($urandom());
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Bursts of back-to-back transactions separated by random gaps
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      idle($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic send_paced(input logic signed [sqmm_pkg::ELEM_W-1:0] a,
                            input logic signed [sqmm_pkg::ELEM_W-1:0] b);
    pace();
    send_item(a, b);
  endtask

  // Wait for all outstanding products, then for the block to go quiet
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_size(input logic [3:0] code);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= 4'($urandom());
    codes_written[code] = 1'b1;
    burst_left = 0;
  endtask

  initial begin
    logic [3:0] code;
    int         n;
    int         runs;
    int         partial;
    int         waited;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Partial load at the reset size, then abandon it
    for (int i = 0; i < 3; i++) send_paced(pick_element(), pick_element());

    write_size(4'd1);
    send_paced(16'sh7FFF, 16'sh7FFF);
    send_paced(16'sh8000, 16'sh8000);
    send_paced(16'sh8000, 16'sh7FFF);

    // Largest positive and most negative sums for a 2x2 product
    write_size(4'd2);
    for (int i = 0; i < 4; i++) send_paced(16'sh8000, 16'sh8000);
    for (int i = 0; i < 4; i++) send_paced(16'sh8000, 16'sh7FFF);

    // Zero size acts as one
    write_size(4'd0);
    send_paced(16'sh0100, 16'shFF00);

    write_size(4'd3);
    send_paced(pick_element(), pick_element());
    send_paced(pick_element(), pick_element());
    write_size(4'd2);
    for (int i = 0; i < 4; i++) send_paced(pick_element(), pick_element());

    while (random_items < 500) begin
      if ($urandom_range(0, 3) == 0) begin
        code = 4'($urandom_range(8, 15));
        if (code == 4'd8) code = 4'd0;
      end else begin
        code = 4'($urandom_range(1, 8));
      end
      write_size(code);
      n    = dim_of(code);
      runs = (n > 5) ? 1 : $urandom_range(1, 3);
      for (int r = 0; r < runs; r++) begin
        for (int e = 0; e < n * n; e++) begin
          send_paced(pick_element(), pick_element());
          random_items++;
        end
        if ($urandom_range(0, 3) == 0) settle();
      end
      // Leave a partial load for the next size write to drop
      if (n > 1 && $urandom_range(0, 4) == 0) begin
        partial = $urandom_range(1, n * n - 1);
        for (int e = 0; e < partial; e++) begin
          send_paced(pick_element(), pick_element());
          random_items++;
        end
      end
    end

    start  <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    stim_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Run covered %0d input transactions and %0d checked product elements,",
             item_count, result_count);
    $display("with %0d distinct size codes written (mask %h).",
             $countones(codes_written), codes_written);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
